// ----- sv/dimc_pkg.sv -----
// Package for the dimuon invariant-mass cut: field widths, register map,
// reset values and result limits. No dependencies.
package dimc_pkg;

  localparam int MOMENTUM_BITS_DEF = 18;

  localparam int PID_W  = 11;
  localparam int MASS_W = 19;
  localparam int RUN_W  = 16;
  localparam int TIME_W = 32;
  localparam int MM2_W  = 20;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int RES_W  = MASS_W + RUN_W + TIME_W;
  localparam int OUT_DW = ((RES_W + 7) / 8) * 8;

  localparam logic [PID_W-1:0]  PID_THRESHOLD_RST = PID_W'(922);
  localparam logic [MASS_W-1:0] MASS_LOW_RST      = MASS_W'(10200);
  localparam logic [MASS_W-1:0] MASS_HIGH_RST     = MASS_W'(10800);
  localparam logic [RUN_W-1:0]  RUN_LIMIT_RST     = RUN_W'(4000);
  localparam logic [MM2_W-1:0]  MUON_MASS_SQ_RST  = MM2_W'(11164);

  localparam logic [MASS_W-1:0] MASS_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PID_THRESHOLD = 3'd0,
    REG_MASS_LOW      = 3'd1,
    REG_MASS_HIGH     = 3'd2,
    REG_RUN_LIMIT     = 3'd3,
    REG_MUON_MASS_SQ  = 3'd4
  } cfg_reg_e;

endpackage

// ----- sv/dimc_isqrt_pipe.sv -----
// Pipelined floor square root, one root bit per register stage, with a
// sideband word carried alongside. No package dependencies.
module dimc_isqrt_pipe #(
  parameter int IN_W = 38,
  parameter int SB_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SB_W-1:0]   sb_i,
  output logic              valid_o,
  output logic [IN_W/2-1:0] root_o,
  output logic [SB_W-1:0]   sb_o
);

  localparam int N  = IN_W / 2;
  localparam int RW = N + 2;

  logic [RW-1:0]   rem_q  [N];
  logic [N-1:0]    root_q [N];
  logic [IN_W-1:0] rad_q  [N];
  logic [SB_W-1:0] sb_q   [N];
  logic            vld_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0]   rem_in;
    logic [N-1:0]    root_in;
    logic [IN_W-1:0] rad_in;
    logic [SB_W-1:0] sb_in;
    logic            vld_in;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic            ge;
    logic [RW-1:0]   rem_d;
    logic [N-1:0]    root_d;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign sb_in   = sb_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign sb_in   = sb_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // bring down the next two radicand bits, try (2*root)*2 + 1
    always_comb begin
      rem_sh = {rem_in[RW-3:0], rad_in[IN_W-1 -: 2]};
      trial  = {root_in, 2'b01};
      ge     = (rem_sh >= trial);
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_in[N-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= rad_in << 2;
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign sb_o    = sb_q[N-1];

endmodule

// ----- sv/dimuon_invariant_mass_cut_unit.sv -----
// Dimuon invariant-mass cut: top level with stream ports and register port.
// Depends on dimc_pkg and dimc_isqrt_pipe.
//
// Usage
//   Input stream (s_axis_*): one two-muon event per request. Output stream
//   (m_axis_*): one request per event that passes the PID, run and mass
//   window cuts; rejected events leave no trace on the output.
//   The user writes registers via cfg_we_i / cfg_idx_i / cfg_data_i only while
//   no event is in flight (not enforced); an index beyond the map is ignored.
// Throughput: one event per clock while the skid slot is free; stages advance together.
// Pipeline, from input accept to output valid: 3 stages of abs/square/sum,
//   MOMENTUM_BITS+1 energy square-root stages, 3 stages of energy
//   sum/square/difference, MOMENTUM_BITS+2 mass square-root stages and the
//   output register. The bit-serial energy and mass square-root pipelines
//   set the depth.
// Stall: the output has a register plus a skid slot. s_axis_tready drops
//   only while the skid slot is full, so the pipeline freezes in place and
//   nothing is lost or repeated; it is a register, not a path from
//   m_axis_tready.
// Reset: all valid bits clear and the registers take their default cut
//   values (PID 922/1024, window 10200..10800 MeV, run < 4000).
module dimuon_invariant_mass_cut_unit #(
  parameter int MOMENTUM_BITS = dimc_pkg::MOMENTUM_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // cfg: register write port
  input  logic                                      cfg_we_i,
  input  logic [dimc_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [dimc_pkg::CFG_DATA_W-1:0]           cfg_data_i,
  // input events
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // tdata, low to high: pid_a, pid_b, mom_a_x, mom_a_y, mom_a_z,
  // mom_b_x, mom_b_y, mom_b_z, run_number, event_time, zero pad
  input  logic [((2*dimc_pkg::PID_W + 6*MOMENTUM_BITS + dimc_pkg::RUN_W
                  + dimc_pkg::TIME_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // selected events
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // tdata, low to high: pair_mass, run_out, time_out, zero pad
  output logic [dimc_pkg::OUT_DW-1:0]               m_axis_tdata
);

  import dimc_pkg::*;

  localparam int MB  = MOMENTUM_BITS;
  localparam int SW  = MB + 1;      // per-axis pair momentum sum
  localparam int SQA = 2 * MB;      // single-muon component squared
  localparam int SQS = 2 * MB + 2;  // pair component squared
  localparam int E2W = 2 * MB + 2;  // E^2 of one muon
  localparam int EW  = E2W / 2;     // energy of one muon
  localparam int ESW = EW + 1;      // energy sum
  localparam int P2W = 2 * MB + 4;  // |p0+p1|^2 and (E0+E1)^2
  localparam int MW  = P2W / 2;     // raw mass
  localparam int MXW = (MW > MASS_W) ? MW : MASS_W;

  localparam int OFS_MOM  = 2 * PID_W;
  localparam int OFS_RUN  = OFS_MOM + 6 * MB;
  localparam int OFS_TIME = OFS_RUN + RUN_W;

  typedef struct packed {
    logic             keep;  // PID and run cuts passed
    logic [RUN_W-1:0] run;
    logic [TIME_W-1:0] tim;
  } evt_t;

  typedef struct packed {
    logic [TIME_W-1:0] tim;
    logic [RUN_W-1:0]  run;
    logic [MASS_W-1:0] mass;
  } res_t;

  // ---------------- configuration registers ----------------
  logic [PID_W-1:0]  pid_thr_q;
  logic [MASS_W-1:0] mass_low_q, mass_high_q;
  logic [RUN_W-1:0]  run_limit_q;
  logic [MM2_W-1:0]  mm2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_thr_q   <= PID_THRESHOLD_RST;
      mass_low_q  <= MASS_LOW_RST;
      mass_high_q <= MASS_HIGH_RST;
      run_limit_q <= RUN_LIMIT_RST;
      mm2_q       <= MUON_MASS_SQ_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PID_THRESHOLD: pid_thr_q   <= cfg_data_i[PID_W-1:0];
        REG_MASS_LOW:      mass_low_q  <= cfg_data_i[MASS_W-1:0];
        REG_MASS_HIGH:     mass_high_q <= cfg_data_i[MASS_W-1:0];
        REG_RUN_LIMIT:     run_limit_q <= cfg_data_i[RUN_W-1:0];
        REG_MUON_MASS_SQ:  mm2_q       <= cfg_data_i[MM2_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves while the skid slot is free
  logic skid_vld_q;
  logic adv;
  assign adv           = !skid_vld_q;
  assign s_axis_tready = adv;

  // ---------------- stage 1: unpack, cuts, magnitudes ----------------
  logic [MB-1:0]     mom [6];
  logic [PID_W-1:0]  in_pid_a, in_pid_b;
  logic [RUN_W-1:0]  in_run;
  logic [TIME_W-1:0] in_time;
  logic [MB-1:0]     abs_d [6];
  logic [SW-1:0]     sum_s [3];
  logic [SW-1:0]     abs_s_d [3];
  evt_t              ev_d;

  always_comb begin
    in_pid_a = s_axis_tdata[0 +: PID_W];
    in_pid_b = s_axis_tdata[PID_W +: PID_W];
    in_run   = s_axis_tdata[OFS_RUN +: RUN_W];
    in_time  = s_axis_tdata[OFS_TIME +: TIME_W];
    for (int i = 0; i < 6; i++) begin
      mom[i]   = s_axis_tdata[OFS_MOM + i*MB +: MB];
      // magnitude of the most negative value is 2^(MB-1), still fits MB bits
      abs_d[i] = mom[i][MB-1] ? (~mom[i] + MB'(1)) : mom[i];
    end
    for (int i = 0; i < 3; i++) begin
      sum_s[i]   = {mom[i][MB-1], mom[i]} + {mom[i+3][MB-1], mom[i+3]};
      abs_s_d[i] = sum_s[i][SW-1] ? (~sum_s[i] + SW'(1)) : sum_s[i];
    end
    ev_d.keep = (in_pid_a >= pid_thr_q) && (in_pid_b >= pid_thr_q)
                && (in_run < run_limit_q);
    ev_d.run  = in_run;
    ev_d.tim  = in_time;
  end

  logic          s1_vld_q;
  evt_t          s1_ev_q;
  logic [MB-1:0] s1_abs_q [6];
  logic [SW-1:0] s1_abs_s_q [3];

  // ---------------- stage 2: squares ----------------
  logic [SQA-1:0] sqm_d [6];
  logic [SQS-1:0] sqs_d [3];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sqm_d[i] = SQA'(s1_abs_q[i]) * SQA'(s1_abs_q[i]);
    end
    for (int i = 0; i < 3; i++) begin
      sqs_d[i] = SQS'(s1_abs_s_q[i]) * SQS'(s1_abs_s_q[i]);
    end
  end

  logic           s2_vld_q;
  evt_t           s2_ev_q;
  logic [SQA-1:0] s2_sqm_q [6];
  logic [SQS-1:0] s2_sqs_q [3];

  // ---------------- stage 3: E^2 per muon, |p0+p1|^2 ----------------
  logic [E2W-1:0] ea2_d, eb2_d;
  logic [P2W-1:0] p2_d;

  always_comb begin
    ea2_d = E2W'(s2_sqm_q[0]) + E2W'(s2_sqm_q[1]) + E2W'(s2_sqm_q[2]) + E2W'(mm2_q);
    eb2_d = E2W'(s2_sqm_q[3]) + E2W'(s2_sqm_q[4]) + E2W'(s2_sqm_q[5]) + E2W'(mm2_q);
    p2_d  = P2W'(s2_sqs_q[0]) + P2W'(s2_sqs_q[1]) + P2W'(s2_sqs_q[2]);
  end

  logic           s3_vld_q;
  evt_t           s3_ev_q;
  logic [E2W-1:0] s3_ea2_q, s3_eb2_q;
  logic [P2W-1:0] s3_p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s_axis_tvalid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ev_q    <= ev_d;
      s1_abs_q   <= abs_d;
      s1_abs_s_q <= abs_s_d;
      s2_ev_q    <= s1_ev_q;
      s2_sqm_q   <= sqm_d;
      s2_sqs_q   <= sqs_d;
      s3_ev_q    <= s2_ev_q;
      s3_ea2_q   <= ea2_d;
      s3_eb2_q   <= eb2_d;
      s3_p2_q    <= p2_d;
    end
  end

  // ---------------- energy square roots ----------------
  // event word rides with the first muon, |p0+p1|^2 with the second
  logic          ea_vld;
  logic [EW-1:0] ea, eb;
  evt_t          ea_ev;
  logic [P2W-1:0] eb_p2;

  dimc_isqrt_pipe #(.IN_W(E2W), .SB_W($bits(evt_t))) u_sqrt_ea (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_vld_q),
    .rad_i   (s3_ea2_q),
    .sb_i    (s3_ev_q),
    .valid_o (ea_vld),
    .root_o  (ea),
    .sb_o    (ea_ev)
  );

  dimc_isqrt_pipe #(.IN_W(E2W), .SB_W(P2W)) u_sqrt_eb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_vld_q),
    .rad_i   (s3_eb2_q),
    .sb_i    (s3_p2_q),
    .valid_o (),
    .root_o  (eb),
    .sb_o    (eb_p2)
  );

  // ---------------- stages 4..6: (E0+E1)^2 - |p|^2 ----------------
  logic           s4_vld_q, s5_vld_q, s6_vld_q;
  evt_t           s4_ev_q, s5_ev_q, s6_ev_q;
  logic [ESW-1:0] s4_es_q;
  logic [P2W-1:0] s4_p2_q, s5_p2_q, s5_e2_q, s6_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= ea_vld;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_ev_q   <= ea_ev;
      s4_p2_q   <= eb_p2;
      s4_es_q   <= ESW'(ea) + ESW'(eb);
      s5_ev_q   <= s4_ev_q;
      s5_p2_q   <= s4_p2_q;
      s5_e2_q   <= P2W'(s4_es_q) * P2W'(s4_es_q);
      s6_ev_q   <= s5_ev_q;
      // spacelike pairs clamp to zero mass
      s6_diff_q <= (s5_e2_q > s5_p2_q) ? (s5_e2_q - s5_p2_q) : '0;
    end
  end

  // ---------------- mass square root ----------------
  logic          m_vld;
  logic [MW-1:0] m_raw;
  evt_t          m_ev;

  dimc_isqrt_pipe #(.IN_W(P2W), .SB_W($bits(evt_t))) u_sqrt_mass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s6_vld_q),
    .rad_i   (s6_diff_q),
    .sb_i    (s6_ev_q),
    .valid_o (m_vld),
    .root_o  (m_raw),
    .sb_o    (m_ev)
  );

  // ---------------- window cut ----------------
  // a saturated mass never sits below mass_high, so it is dropped
  logic [MXW-1:0]    m_ext;
  logic [MASS_W-1:0] m_sat;
  logic              hit;
  logic              push;
  res_t              res_d;

  always_comb begin
    m_ext      = MXW'(m_raw);
    m_sat      = (m_ext > MXW'(MASS_MAX)) ? MASS_MAX : m_ext[MASS_W-1:0];
    hit        = m_vld && m_ev.keep && (m_sat > mass_low_q) && (m_sat < mass_high_q);
    push       = adv && hit;
    res_d.mass = m_sat;
    res_d.run  = m_ev.run;
    res_d.tim  = m_ev.tim;
  end

  // ---------------- output register and skid slot ----------------
  logic out_vld_q;
  res_t out_q, skid_q;
  logic pop;

  assign pop = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      // pipeline frozen: drain skid into output
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (out_vld_q && !pop) begin
      if (push) begin
        skid_vld_q <= 1'b1;
      end
    end else begin
      out_vld_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (out_vld_q && !pop) begin
      if (push) begin
        skid_q <= res_d;
      end
    end else if (push) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DW'(out_q);

`ifndef SYNTHESIS
  // skid slot is only ever filled behind a held output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid slot full while output register empty");

  // a frozen pipeline keeps its entry stage
  a_freeze_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s1_vld_q))
    else $error("pipeline moved while stalled");

  // a result arriving behind a stalled output must land in the skid slot
  a_push_to_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_vld_q && !m_axis_tready) |=> skid_vld_q)
    else $error("result lost behind stalled output");
`endif

endmodule

// ----- sim/dimuon_invariant_mass_cut_unit_tb.sv -----
// Self-checking bench for the dimuon invariant-mass cut unit: it streams events
// and compares every selected event against an in-bench integer model.
// Depends on dimc_pkg and the unit under test.
`timescale 1ns / 1ps

module dimuon_invariant_mass_cut_unit_tb;
  import dimc_pkg::*;

  localparam int MB        = MOMENTUM_BITS_DEF;
  localparam int IN_DW     = ((2*PID_W + 6*MB + RUN_W + TIME_W + 7) / 8) * 8;
  // Input to output depth at this width, summed from the unit's stage list.
  localparam int LATENCY   = 2*MB + 10;
  localparam int LIMIT     = 300000;
  localparam int HOLD_LONG = 400;

  // Indexes past the register map; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct {
    logic [PID_W-1:0]     pid_a;
    logic [PID_W-1:0]     pid_b;
    logic signed [MB-1:0] mom[6];   // a_x, a_y, a_z, b_x, b_y, b_z
    logic [RUN_W-1:0]     run;
    logic [TIME_W-1:0]    stamp;
  } event_t;

  typedef struct {
    logic [MASS_W-1:0] mass;
    logic [RUN_W-1:0]  run;
    logic [TIME_W-1:0] stamp;
  } selection_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // low to high: pid_a, pid_b, mom_a_x/y/z, mom_b_x/y/z, run_number, event_time, pad
  logic [IN_DW-1:0]      s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // low to high: pair_mass, run_out, time_out, pad
  logic [OUT_DW-1:0]     m_axis_tdata;

  // Shadow copy of the cut registers, updated as the bench writes them.
  logic [PID_W-1:0]  cut_pid;
  logic [MASS_W-1:0] cut_mass_lo;
  logic [MASS_W-1:0] cut_mass_hi;
  logic [RUN_W-1:0]  cut_run_limit;
  logic [MM2_W-1:0]  cut_mm2;

  selection_t expected_selections[$];
  int  failures;
  int  cycle_count;
  bit  sender_gaps;
  bit  receiver_gaps;
  int  hold_len;       // long receiver hold-off request, in cycles

  dimuon_invariant_mass_cut_unit #(
    .MOMENTUM_BITS(MB)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Integer model of the cut
  // ---------------------------------------------------------------------------

  // Floor square root, one result bit per step from the top. Every argument
  // here stays well below 2^40, so 32 result bits are plenty.
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Pair mass with the energy floors, the zero clamp and the 19-bit ceiling.
  function automatic logic [MASS_W-1:0] pair_mass(input event_t ev,
                                                  input logic [MM2_W-1:0] mm2);
    longint sq_a, sq_b, sq_sum, comp, e_a, e_b, e_sum, e_sq, m;
    sq_a   = longint'(mm2);
    sq_b   = longint'(mm2);
    sq_sum = 0;
    for (int i = 0; i < 3; i++) begin
      sq_a   += longint'(ev.mom[i]) * longint'(ev.mom[i]);
      sq_b   += longint'(ev.mom[i+3]) * longint'(ev.mom[i+3]);
      comp    = longint'(ev.mom[i]) + longint'(ev.mom[i+3]);
      sq_sum += comp * comp;
    end
    e_a   = longint'(floor_root(sq_a));
    e_b   = longint'(floor_root(sq_b));
    e_sum = e_a + e_b;
    e_sq  = e_sum * e_sum;
    m     = (e_sq > sq_sum) ? longint'(floor_root(e_sq - sq_sum)) : 0;
    if (m > longint'(MASS_MAX)) m = longint'(MASS_MAX);
    return m[MASS_W-1:0];
  endfunction

  // Queues the selected event, if the current cuts let it through.
  function automatic void predict_selection(input event_t ev);
    selection_t sel;
    if (ev.pid_a < cut_pid || ev.pid_b < cut_pid) return;
    sel.mass  = pair_mass(ev, cut_mm2);
    sel.run   = ev.run;
    sel.stamp = ev.stamp;
    if (sel.mass > cut_mass_lo && sel.mass < cut_mass_hi && ev.run < cut_run_limit)
      expected_selections.push_back(sel);
  endfunction

  // ---------------------------------------------------------------------------
  // Event generation
  // ---------------------------------------------------------------------------

  function automatic logic signed [MB-1:0] clip_mom(input longint v);
    longint top;
    top = (longint'(1) <<< (MB-1)) - 1;
    if (v > top) v = top;
    if (v < -top - 1) v = -top - 1;
    return v[MB-1:0];
  endfunction

  // Back-to-back pair aimed at a given mass, then boosted by a common
  // momentum of up to +-boost per axis, which pulls the mass off target.
  function automatic event_t decay_event(input longint unsigned target,
                                         input int unsigned boost);
    event_t ev;
    longint d[3];
    longint norm, pmag, c, k;
    longint unsigned psq;
    psq = target * target / 4;
    psq = (psq > cut_mm2) ? psq - cut_mm2 : 0;
    pmag = longint'(floor_root(psq));
    for (int i = 0; i < 3; i++) d[i] = longint'($urandom_range(0, 2000)) - 1000;
    norm = longint'(floor_root(d[0]*d[0] + d[1]*d[1] + d[2]*d[2]));
    if (norm == 0) begin
      d[0] = 1000;
      norm = 1000;
    end
    for (int i = 0; i < 3; i++) begin
      c = d[i] * pmag / norm;
      k = longint'($urandom_range(0, 2*boost)) - longint'(boost);
      ev.mom[i]   = clip_mom(c + k);
      ev.mom[i+3] = clip_mom(-c + k);
    end
    ev.pid_a = PID_W'($urandom_range(cut_pid, 2047));
    ev.pid_b = PID_W'($urandom_range(cut_pid, 2047));
    ev.run   = (cut_run_limit != 0) ? RUN_W'($urandom_range(0, cut_run_limit - 1))
                                    : RUN_W'($urandom);
    ev.stamp = $urandom;
    return ev;
  endfunction

  // Mostly well-formed candidates near the window; the rest is raw noise
  // that toggles every field bit, or a pair broken on PID or run.
  function automatic event_t random_event();
    event_t ev;
    longint unsigned target;
    int unsigned boost;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      ev.pid_a = PID_W'($urandom);
      ev.pid_b = PID_W'($urandom);
      for (int i = 0; i < 6; i++) ev.mom[i] = MB'($urandom);
      ev.run   = RUN_W'($urandom);
      ev.stamp = $urandom;
      return ev;
    end
    if (cut_mass_hi > cut_mass_lo + 1)
      target = $urandom_range(cut_mass_lo + 1, cut_mass_hi - 1);
    else
      target = $urandom_range(0, 300000);
    case ($urandom_range(0, 3))
      0: boost = 0;
      1: boost = 16;
      2: boost = 256;
      default: boost = 4096;
    endcase
    ev = decay_event(target, boost);
    if (pick < 20) ev.pid_a = PID_W'($urandom);
    else if (pick < 25) ev.pid_b = PID_W'($urandom);
    else if (pick < 30) ev.run = RUN_W'($urandom);
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  function automatic logic [IN_DW-1:0] pack_event(input event_t ev);
    logic [IN_DW-1:0] w;
    w = '0;
    w[0 +: PID_W]     = ev.pid_a;
    w[PID_W +: PID_W] = ev.pid_b;
    for (int i = 0; i < 6; i++) w[2*PID_W + i*MB +: MB] = ev.mom[i];
    w[2*PID_W + 6*MB +: RUN_W]          = ev.run;
    w[2*PID_W + 6*MB + RUN_W +: TIME_W] = ev.stamp;
    return w;
  endfunction

  // Offers one event, optionally after a gap; returns at the accepting edge
  // with tvalid still high so back-to-back requests follow without a gap.
  task automatic send_event(input event_t ev);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_event(ev);
    do @(posedge clk_i); while (!s_axis_tready);
    predict_selection(ev);
  endtask

  // Idle the input, wait for every queued selection, then let any rejected
  // events still in the pipe run out before the cuts may change.
  task automatic settle_pipeline();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_selections.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_PID_THRESHOLD: cut_pid       = val[PID_W-1:0];
      REG_MASS_LOW:      cut_mass_lo   = val[MASS_W-1:0];
      REG_MASS_HIGH:     cut_mass_hi   = val[MASS_W-1:0];
      REG_RUN_LIMIT:     cut_run_limit = val[RUN_W-1:0];
      REG_MUON_MASS_SQ:  cut_mm2       = val[MM2_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_cuts(input logic [PID_W-1:0] pid, input logic [MASS_W-1:0] lo,
                            input logic [MASS_W-1:0] hi, input logic [RUN_W-1:0] rl,
                            input logic [MM2_W-1:0] mm2);
    write_reg(REG_PID_THRESHOLD, CFG_DATA_W'(pid));
    write_reg(REG_MASS_LOW, CFG_DATA_W'(lo));
    write_reg(REG_MASS_HIGH, CFG_DATA_W'(hi));
    write_reg(REG_RUN_LIMIT, CFG_DATA_W'(rl));
    write_reg(REG_MUON_MASS_SQ, CFG_DATA_W'(mm2));
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_event(random_event());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  // tready: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // Each accepted result against the oldest queued selection.
  always @(posedge clk_i) begin : check_selections
    selection_t want;
    selection_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.mass  = m_axis_tdata[0 +: MASS_W];
      got.run   = m_axis_tdata[MASS_W +: RUN_W];
      got.stamp = m_axis_tdata[MASS_W + RUN_W +: TIME_W];
      if (expected_selections.size() == 0) begin
        note_failure($sformatf("unexpected event: mass %0d run %0d time %0h",
                               got.mass, got.run, got.stamp));
      end else begin
        want = expected_selections.pop_front();
        if (got.mass !== want.mass)
          note_failure($sformatf("pair_mass: expected %0d, got %0d", want.mass, got.mass));
        if (got.run !== want.run)
          note_failure($sformatf("run_out: expected %0d, got %0d", want.run, got.run));
        if (got.stamp !== want.stamp)
          note_failure($sformatf("time_out: expected %0h, got %0h", want.stamp, got.stamp));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Both scores against the reset threshold: at it, one below, above 1024,
  // and zero. The pair itself sits in the default window.
  task automatic test_pid_cut();
    event_t ev;
    ev = decay_event(10500, 0);
    ev.pid_a = PID_W'(922); ev.pid_b = PID_W'(1024); send_event(ev);
    ev.pid_a = PID_W'(921); ev.pid_b = PID_W'(1024); send_event(ev);
    ev.pid_a = PID_W'(1024); ev.pid_b = PID_W'(921); send_event(ev);
    ev.pid_a = PID_W'(2047); ev.pid_b = PID_W'(2047); send_event(ev);
    ev.pid_a = '0; ev.pid_b = '0; send_event(ev);
  endtask

  // Run limit is exclusive; time stamps pass through at both extremes.
  task automatic test_run_cut();
    event_t ev;
    ev = decay_event(10500, 0);
    ev.pid_a = PID_W'(1000); ev.pid_b = PID_W'(1000);
    ev.run = RUN_W'(3999); ev.stamp = '1; send_event(ev);
    ev.run = RUN_W'(4000); send_event(ev);
    ev.run = '1; send_event(ev);
    ev.run = '0; ev.stamp = '0; send_event(ev);
  endtask

  // Both window edges are exclusive: place them around a known mass.
  task automatic test_window_edges();
    event_t ev;
    logic [MASS_W-1:0] m;
    ev = decay_event(10500, 32);
    ev.pid_a = PID_W'(1024); ev.pid_b = PID_W'(1024); ev.run = RUN_W'(7);
    m = pair_mass(ev, cut_mm2);
    settle_pipeline();
    write_reg(REG_MASS_LOW, CFG_DATA_W'(m - 1));
    write_reg(REG_MASS_HIGH, CFG_DATA_W'(m + 1));
    send_event(ev);
    settle_pipeline();
    write_reg(REG_MASS_LOW, CFG_DATA_W'(m));
    send_event(ev);
    settle_pipeline();
    write_reg(REG_MASS_LOW, CFG_DATA_W'(m - 1));
    write_reg(REG_MASS_HIGH, CFG_DATA_W'(m));
    send_event(ev);
    settle_pipeline();
  endtask

  // Over-wide data is cut to the register width, unmapped indexes are
  // dropped; then momentum extremes and a pair whose mass squared goes
  // negative from the energy floors.
  task automatic test_register_writes();
    event_t ev;
    write_reg(REG_PID_THRESHOLD, '1);
    write_reg(REG_MASS_LOW, '1);
    write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
    write_reg(REG_UNMAPPED_HI, CFG_DATA_W'($urandom));
    ev = decay_event(10500, 0);
    ev.pid_a = '1; ev.pid_b = '1; send_event(ev);
    settle_pipeline();
    write_cuts(PID_W'(0), MASS_W'(0), MASS_MAX, RUN_W'(65535), MM2_W'(0));
    ev.pid_a = '0; ev.pid_b = '0; ev.run = '1; ev.stamp = $urandom;
    for (int i = 0; i < 6; i++) ev.mom[i] = '0;
    ev.mom[0] = MB'(1); ev.mom[1] = MB'(1); ev.mom[3] = MB'(1); ev.mom[4] = MB'(1);
    send_event(ev);
    for (int i = 0; i < 3; i++) begin
      ev.mom[i]   = {1'b0, {(MB-1){1'b1}}};
      ev.mom[i+3] = {1'b1, {(MB-1){1'b0}}};
    end
    send_event(ev);
    for (int i = 0; i < 6; i++) ev.mom[i] = {1'b1, {(MB-1){1'b0}}};
    send_event(ev);
    ev.mom[0] = MB'(5000); ev.mom[3] = MB'(-5000);
    for (int i = 1; i < 3; i++) begin
      ev.mom[i] = '0; ev.mom[i+3] = '0;
    end
    ev.stamp = '1;
    send_event(ev);
    settle_pipeline();
    write_reg(REG_MUON_MASS_SQ, '1);
    send_event(ev);
    settle_pipeline();
  endtask

  // Random traffic under several cut settings, the extremes among them.
  task automatic test_config_sweep();
    logic [MASS_W-1:0] lo;
    // wide open: any event with nonzero mass and a run below 65535 passes
    write_cuts(PID_W'(0), MASS_W'(0), MASS_MAX, RUN_W'(65535), '1);
    send_random(250);
    settle_pipeline();
    // closed: highest threshold and a run limit of zero pass nothing
    write_cuts('1, MASS_W'(1000), MASS_W'(900000 % 524288), RUN_W'(0), MM2_W'(0));
    send_random(60);
    settle_pipeline();
    for (int p = 0; p < 4; p++) begin
      lo = MASS_W'($urandom_range(0, 200000));
      write_cuts(PID_W'($urandom_range(0, 1100)), lo,
                 MASS_W'(lo + $urandom_range(2, 20000)),
                 RUN_W'($urandom_range(1, 65535)), MM2_W'($urandom));
      send_random(230);
      settle_pipeline();
    end
    write_cuts(PID_THRESHOLD_RST, MASS_LOW_RST, MASS_HIGH_RST, RUN_LIMIT_RST,
               MUON_MASS_SQ_RST);
  endtask

  // The receiver holds off long enough for the pipe and the skid slot to
  // fill, so tready on the input has to drop while events keep coming.
  task automatic test_output_backpressure();
    write_reg(REG_PID_THRESHOLD, CFG_DATA_W'(0));
    write_reg(REG_RUN_LIMIT, CFG_DATA_W'(65535));
    hold_len = HOLD_LONG;
    send_random(200);
    settle_pipeline();
  endtask

  // Full-rate tail: no gaps on either side.
  task automatic test_unthrottled_tail();
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    send_random(300);
  endtask

  initial begin
    failures      = 0;
    hold_len      = 0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cut_pid       = PID_THRESHOLD_RST;
    cut_mass_lo   = MASS_LOW_RST;
    cut_mass_hi   = MASS_HIGH_RST;
    cut_run_limit = RUN_LIMIT_RST;
    cut_mm2       = MUON_MASS_SQ_RST;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_pid_cut();
    test_run_cut();
    test_window_edges();
    test_register_writes();
    test_config_sweep();
    test_output_backpressure();
    test_unthrottled_tail();

    settle_pipeline();
    if (failures == 0 && expected_selections.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/dimc_pkg.sv
sv/dimc_isqrt_pipe.sv
sv/dimuon_invariant_mass_cut_unit.sv
sim/dimuon_invariant_mass_cut_unit_tb.sv
